[rtl/core/dym_pkg.sv]
// Shared types, constants and calendar helpers for the day-of-year to
// month/day converter. No dependencies.
package dym_pkg;

  localparam int unsigned YEAR_BITS  = 14;
  localparam int unsigned MONTH_BITS = 4;
  localparam int unsigned DAY_BITS   = 5;
  localparam int unsigned R400_BITS  = 9;
  localparam int unsigned LEN_BITS   = 11;

  localparam logic [R400_BITS-1:0] CYCLE_YEARS = 9'd400;
  localparam logic [LEN_BITS-1:0]  YEAR_DAYS   = 11'd365;
  localparam logic [LEN_BITS-1:0]  BLOCK_DAYS  = 11'd1460;

  localparam int unsigned          RED_STEPS = 6;
  localparam int unsigned          STEP_BITS = 3;
  localparam logic [STEP_BITS-1:0] STEP_LAST = 3'(RED_STEPS - 1);

  typedef struct packed {
    logic [YEAR_BITS-1:0] year;
    logic [R400_BITS-1:0] r400;
  } year_info_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_REDUCE,
    FR_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_YEAR,
    BK_MONTH,
    BK_DONE
  } back_state_e;

  // year mod 400 is 0 or not a multiple of 100, and a multiple of 4
  function automatic logic is_leap(input logic [R400_BITS-1:0] r);
    logic century;
    century = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
    return (r == 9'd0) || (!century && (r[1:0] == 2'b00));
  endfunction

  function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] mon,
                                                    input logic                  leap);
    logic [DAY_BITS-1:0] len;
    unique case (mon)
      4'd0:    len = 5'd31;
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // 400 << step, subtrahend for the mod-400 reduction
  function automatic logic [YEAR_BITS-1:0] r400_sub(input logic [STEP_BITS-1:0] step);
    return YEAR_BITS'(CYCLE_YEARS) << step;
  endfunction

endpackage

[rtl/core/day_of_year_to_month_day.sv]
// Top level of the day-of-year to month/day converter.
// Depends on dym_pkg, dym_front, dym_fifo and dym_back.
//
// Input channel: day_count_i (1 = January 1) and start_year_i, qualified by
// in_valid_i; a word is taken on a clock edge with in_valid_i high and
// in_stall_o low. Output channel: result_year_o, month_number_o and
// day_of_month_o under out_valid_o, taken when out_stall_i is low.
// The front end takes a word, reduces the year mod 400 step by step and
// then hands it to a two-entry queue; it takes no new word until that push
// is done. The walker loads a word from the queue, skips four-year blocks
// and then single years, leaves that stage, then steps through the months
// and settles; out_valid_o rises once the month steps are done.
// The walker runs one conversion at a time and starts a new one only after
// its result is taken; the front end and queue keep taking words while a
// result waits, until the queue is full.
// A result stays on the outputs, unchanged, as long as out_stall_i is high.
// Reset (rst_ni low) empties the queue and returns both sides to idle; no
// item in flight survives it.
module day_of_year_to_month_day #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [COUNT_BITS-1:0]          day_count_i,
  input  logic [dym_pkg::YEAR_BITS-1:0]  start_year_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [dym_pkg::YEAR_BITS-1:0]  result_year_o,
  output logic [dym_pkg::MONTH_BITS-1:0] month_number_o,
  output logic [dym_pkg::DAY_BITS-1:0]   day_of_month_o
);
  import dym_pkg::*;

  localparam int unsigned Q_WIDTH = COUNT_BITS + $bits(year_info_t);

  logic                  push_valid, push_full, q_empty, q_rd;
  logic [COUNT_BITS-1:0] push_count, q_count;
  year_info_t            push_info, q_info;
  logic [Q_WIDTH-1:0]    q_rd_data;

  dym_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .day_count_i (day_count_i),
    .start_year_i(start_year_i),
    .push_valid_o(push_valid),
    .push_full_i (push_full),
    .push_count_o(push_count),
    .push_info_o (push_info)
  );

  dym_fifo #(
    .WIDTH(Q_WIDTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(push_valid),
    .full_o    (push_full),
    .wr_data_i ({push_count, push_info}),
    .rd_i      (q_rd),
    .empty_o   (q_empty),
    .rd_data_o (q_rd_data)
  );

  assign q_count = q_rd_data[Q_WIDTH-1 -: COUNT_BITS];
  assign q_info  = year_info_t'(q_rd_data[$bits(year_info_t)-1:0]);

  dym_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_rd_o        (q_rd),
    .q_count_i     (q_count),
    .q_info_i      (q_info),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_year_o (result_year_o),
    .month_number_o(month_number_o),
    .day_of_month_o(day_of_month_o)
  );

endmodule

[rtl/core/dym_front.sv]
// Front end: accepts a word and reduces the start year mod 400.
// Depends on dym_pkg.
module dym_front #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [COUNT_BITS-1:0]         day_count_i,
  input  logic [dym_pkg::YEAR_BITS-1:0] start_year_i,
  output logic                          push_valid_o,
  input  logic                          push_full_i,
  output logic [COUNT_BITS-1:0]         push_count_o,
  output dym_pkg::year_info_t           push_info_o
);
  import dym_pkg::*;

  front_state_e         state_q, state_d;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [YEAR_BITS-1:0] year_q;
  logic [YEAR_BITS-1:0] rem_q;
  logic [STEP_BITS-1:0] step_q;
  logic [YEAR_BITS-1:0] sub;

  assign sub = r400_sub(step_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FR_IDLE:   if (in_valid_i) state_d = FR_REDUCE;
      FR_REDUCE: if (step_q == '0) state_d = FR_PUSH;
      FR_PUSH:   if (!push_full_i) state_d = FR_IDLE;
      default:   state_d = FR_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o   = (state_q != FR_IDLE);
    push_valid_o = (state_q == FR_PUSH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FR_IDLE && in_valid_i) begin
      cnt_q  <= day_count_i;
      year_q <= start_year_i;
      rem_q  <= start_year_i;
      step_q <= STEP_LAST;
    end else if (state_q == FR_REDUCE) begin
      if (rem_q >= sub) rem_q <= rem_q - sub;
      step_q <= step_q - 1'b1;
    end
  end

  assign push_count_o     = cnt_q;
  assign push_info_o.year = year_q;
  assign push_info_o.r400 = rem_q[R400_BITS-1:0];

endmodule

[rtl/core/dym_fifo.sv]
// Two-entry queue between the front end and the calendar walker.
// Depends on dym_pkg only for house style.
module dym_fifo #(
  parameter int unsigned WIDTH = 39
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rd_data_o
);
  import dym_pkg::*;

  localparam int unsigned DEPTH    = 2;
  localparam int unsigned PTR_BITS = $clog2(DEPTH);
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_q [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_BITS-1:0] fill_q;
  logic                do_wr, do_rd;

  assign full_o    = (fill_q == CNT_BITS'(DEPTH));
  assign empty_o   = (fill_q == '0);
  assign do_wr     = wr_valid_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_wr && !do_rd) begin
        fill_q <= fill_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

[rtl/core/dym_back.sv]
// Calendar walker: skips four-year blocks, single years, then months,
// and holds the result until taken. Depends on dym_pkg.
module dym_back #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  output logic                           q_rd_o,
  input  logic [COUNT_BITS-1:0]          q_count_i,
  input  dym_pkg::year_info_t            q_info_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [dym_pkg::YEAR_BITS-1:0]  result_year_o,
  output logic [dym_pkg::MONTH_BITS-1:0] month_number_o,
  output logic [dym_pkg::DAY_BITS-1:0]   day_of_month_o
);
  import dym_pkg::*;

  localparam int unsigned CMP_BITS = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;

  back_state_e           state_q, state_d;
  logic [COUNT_BITS-1:0] count_q;
  logic [YEAR_BITS-1:0]  year_q;
  logic [R400_BITS-1:0]  r400_q;
  logic [MONTH_BITS-1:0] mon_q;

  logic [1:0]            off;
  logic [YEAR_BITS:0]    z_sum, sum4, sum1;
  logic [R400_BITS-1:0]  z_raw, z_r400, r4_raw, r4_next, r1_raw, r1_next;
  logic                  leap_cur;
  logic [LEN_BITS-1:0]   blk_len, yr_len;
  logic [CMP_BITS-1:0]   count_ext, blk_ext, yr_ext, blk_rem, yr_rem;
  logic                  take4, take1;
  logic [DAY_BITS-1:0]   mlen;
  logic                  take_mon;

  // leap candidate inside [year, year+3]; 16384 is a multiple of 4
  assign off    = 2'(-r400_q[1:0]);
  assign z_sum  = {1'b0, year_q} + (YEAR_BITS+1)'(off);
  assign z_raw  = r400_q + R400_BITS'(off);
  assign z_r400 = z_sum[YEAR_BITS] ? '0 :
                  (z_raw >= CYCLE_YEARS) ? z_raw - CYCLE_YEARS : z_raw;

  assign leap_cur = is_leap(r400_q);
  assign blk_len  = BLOCK_DAYS + LEN_BITS'(is_leap(z_r400));
  assign yr_len   = YEAR_DAYS + LEN_BITS'(leap_cur);

  assign count_ext = CMP_BITS'(count_q);
  assign blk_ext   = CMP_BITS'(blk_len);
  assign yr_ext    = CMP_BITS'(yr_len);
  assign blk_rem   = count_ext - blk_ext;
  assign yr_rem    = count_ext - yr_ext;
  assign take4     = count_ext > blk_ext;
  assign take1     = count_ext > yr_ext;

  assign sum4    = {1'b0, year_q} + (YEAR_BITS+1)'(4);
  assign sum1    = {1'b0, year_q} + (YEAR_BITS+1)'(1);
  assign r4_raw  = r400_q + R400_BITS'(4);
  assign r1_raw  = r400_q + R400_BITS'(1);
  assign r4_next = sum4[YEAR_BITS] ? sum4[R400_BITS-1:0] :
                   (r4_raw >= CYCLE_YEARS) ? r4_raw - CYCLE_YEARS : r4_raw;
  assign r1_next = sum1[YEAR_BITS] ? sum1[R400_BITS-1:0] :
                   (r1_raw >= CYCLE_YEARS) ? r1_raw - CYCLE_YEARS : r1_raw;

  assign mlen     = month_len(mon_q, leap_cur);
  assign take_mon = count_q > COUNT_BITS'(mlen);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (!q_empty_i) state_d = BK_YEAR;
      BK_YEAR:  if (!take4 && !take1) state_d = BK_MONTH;
      BK_MONTH: if (!take_mon) state_d = BK_DONE;
      BK_DONE:  if (!out_stall_i) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_rd_o      = (state_q == BK_IDLE) && !q_empty_i;
    out_valid_o = (state_q == BK_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          count_q <= q_count_i;
          year_q  <= q_info_i.year;
          r400_q  <= q_info_i.r400;
          mon_q   <= '0;
        end
      end
      BK_YEAR: begin
        priority if (take4) begin
          count_q <= blk_rem[COUNT_BITS-1:0];
          year_q  <= sum4[YEAR_BITS-1:0];
          r400_q  <= r4_next;
        end else if (take1) begin
          count_q <= yr_rem[COUNT_BITS-1:0];
          year_q  <= sum1[YEAR_BITS-1:0];
          r400_q  <= r1_next;
        end else begin
          count_q <= count_q;
        end
      end
      BK_MONTH: begin
        if (take_mon) begin
          count_q <= count_q - COUNT_BITS'(mlen);
          mon_q   <= mon_q + 1'b1;
        end
      end
      BK_DONE: begin
        count_q <= count_q;
      end
      default: begin
        count_q <= count_q;
      end
    endcase
  end

  assign result_year_o  = year_q;
  assign month_number_o = mon_q + 1'b1;
  assign day_of_month_o = count_q[DAY_BITS-1:0];

endmodule

[rtl/core/dym_checker.sv]
// Port-level checks for day_of_year_to_month_day, attached by bind.
// Depends on dym_pkg.
module dym_checker #(
  parameter int unsigned COUNT_BITS = 16
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic [COUNT_BITS-1:0]          day_count_i,
  input logic [dym_pkg::YEAR_BITS-1:0]  start_year_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [dym_pkg::YEAR_BITS-1:0]  result_year_o,
  input logic [dym_pkg::MONTH_BITS-1:0] month_number_o,
  input logic [dym_pkg::DAY_BITS-1:0]   day_of_month_o
);
  import dym_pkg::*;

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(day_count_i)
                                 && $stable(start_year_i))
    else $error("input word dropped or changed while stalled");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_year_o)
                                   && $stable(month_number_o) && $stable(day_of_month_o))
    else $error("result dropped or changed while stalled");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> month_number_o >= 4'd1 && month_number_o <= 4'd12)
    else $error("month out of range");

  a_day_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && month_number_o != 4'd1 |-> day_of_month_o != 5'd0)
    else $error("day zero outside January");

  a_day_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (month_number_o != 4'd2 || day_of_month_o <= 5'd29) &&
                    (month_number_o != 4'd4 || day_of_month_o <= 5'd30) &&
                    (month_number_o != 4'd6 || day_of_month_o <= 5'd30) &&
                    (month_number_o != 4'd9 || day_of_month_o <= 5'd30) &&
                    (month_number_o != 4'd11 || day_of_month_o <= 5'd30))
    else $error("day beyond month length");

endmodule

bind day_of_year_to_month_day dym_checker #(.COUNT_BITS(COUNT_BITS)) u_dym_checker (.*);
